// ===== rtl/core/cdbu_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdbu_pkg
// Shared types and constants for the half-duplex collision-detect bit UART.
// ============================================================================
package cdbu_pkg;

    localparam int BUF_DEPTH = 128;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int LEN_W     = $clog2(BUF_DEPTH + 1);

    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(BUF_DEPTH);

    localparam logic [7:0] CHECK_SEED = 8'hFF;
    localparam logic [7:0] DATA_MSB   = 8'h80;
    localparam logic [7:0] TICK_SAT   = 8'hFF;
    localparam logic [7:0] STOP_TICK  = 8'd9;

    typedef enum logic [2:0] {
        CMD_LOAD  = 3'd0,
        CMD_TRY   = 3'd1,
        CMD_EDGE  = 3'd2,
        CMD_CHECK = 3'd3,
        CMD_TICK  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_BACKOFF = 3'd1,
        MODE_BREAK   = 3'd2,
        MODE_TX      = 3'd3,
        MODE_RX      = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_STARTED = 3'd1,
        ST_CARRIER = 3'd2,
        ST_PRIO    = 3'd3,
        ST_BUSY    = 3'd4,
        ST_DONE    = 3'd5,
        ST_COLL    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        SQ_RUN   = 2'd0,
        SQ_SWEEP = 2'd1,
        SQ_FOLD  = 2'd2,
        SQ_FIN   = 2'd3
    } seq_t;

    localparam logic [1:0] CFG_BACKOFF_LIMIT = 2'd0;
    localparam logic [1:0] CFG_CARRIER_TICKS = 2'd1;
    localparam logic [1:0] CFG_BREAK_TICKS   = 2'd2;

endpackage

// ===== rtl/core/collision_detect_bit_uart_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// collision_detect_bit_uart_top
// Event-driven half-duplex UART on an open-drain bus with collision break,
// carrier / priority backoff and an XOR packet checksum.
// ============================================================================
//
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_stall  | command, buf_index, buf_byte, packet_length,
//          |                      | priority_delay, edge_pending, line_now,
//          |                      | sample_early, sample_mid
// out      | out_valid / out_stall| drive_low, rx_valid, rx_data, rx_error,
//          |                      | tx_status, collision_end, bus_state
// cfg      | cfg_valid / cfg_ready| cfg_index (0 backoff_limit, 1 carrier_ticks,
//          |                      | 2 break_ticks), cfg_data
//
// Loads, edges, checks and ticks are handled on acceptance; a new request can
// be accepted every cycle while in_stall is low, and its result lands in the
// output reg in the next cycle. A transmit try sweeps buffer bytes 0 to
// packet_length - 2 (one read port) to form the checksum, stores it at byte
// packet_length - 1 (clipped to 2..128); in_stall is high all the while.
// Buffer RAM and payload registers have no reset; all else clears on rst_n low.
// out_stall holds the output register; the input is taken while the output
// register is free or being emptied in the same cycle.
// ============================================================================
module collision_detect_bit_uart_top (
    input  logic       clk,
    input  logic       rst_n,
    // request channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] command,
    input  logic [6:0] buf_index,
    input  logic [7:0] buf_byte,
    input  logic [7:0] packet_length,
    input  logic [7:0] priority_delay,
    input  logic       edge_pending,
    input  logic       line_now,
    input  logic       sample_early,
    input  logic       sample_mid,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       drive_low,
    output logic       rx_valid,
    output logic [7:0] rx_data,
    output logic       rx_error,
    output logic [2:0] tx_status,
    output logic       collision_end,
    output logic [2:0] bus_state,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import cdbu_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] backoff_limit_reg;
    logic [7:0] carrier_ticks_reg;
    logic [7:0] break_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backoff_limit_reg <= 8'd40;
            carrier_ticks_reg <= 8'd20;
            break_ticks_reg   <= 8'd15;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BACKOFF_LIMIT: backoff_limit_reg <= cfg_data;
                CFG_CARRIER_TICKS: carrier_ticks_reg <= cfg_data;
                CFG_BREAK_TICKS:   break_ticks_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Protocol state
    // ------------------------------------------------------------------
    mode_t            mode_reg, mode_next;
    logic             start_seen_reg, start_seen_next;
    logic [7:0]       tick_count_reg, tick_count_next;
    logic [7:0]       shift_byte_reg, shift_byte_next;
    logic [BUF_AW-1:0] send_position_reg, send_position_next;
    logic [LEN_W-1:0] send_length_reg, send_length_next;
    logic             line_pulled_reg, line_pulled_next;

    // try sequencer
    seq_t             seq_reg, seq_next;
    logic [BUF_AW-1:0] sweep_idx_reg, sweep_idx_next;
    logic             land_reg, land_next;
    logic             land_first_reg, land_first_next;
    logic [7:0]       chk_reg, chk_next;
    logic [7:0]       first_reg, first_next;
    logic [LEN_W-1:0] try_len_reg, try_len_next;
    logic [7:0]       try_prio_reg, try_prio_next;
    logic             try_edge_reg, try_edge_next;

    // prefetched byte at send_position + 1
    logic [7:0]       next_byte_reg, next_byte_next;
    logic             fetch_land_reg;
    logic             fetch_hit_reg;
    logic [7:0]       fetch_wd_reg;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic             drive_low_reg, drive_low_next;
    logic             rx_valid_reg, rx_valid_next;
    logic [7:0]       rx_data_reg, rx_data_next;
    logic             rx_error_reg, rx_error_next;
    status_t          tx_status_reg, tx_status_next;
    logic             coll_end_reg, coll_end_next;
    mode_t            bus_state_reg, bus_state_next;

    // buffer RAM
    logic [7:0]        buf_mem [BUF_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              mem_we;
    logic [BUF_AW-1:0] mem_wa;
    logic [7:0]        mem_wd;
    logic [BUF_AW-1:0] mem_ra;
    logic              fetch_issue;
    logic [BUF_AW-1:0] fetch_addr;

    logic              slot_free;
    logic              accept;
    logic [BUF_AW-1:0] nb_addr;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (seq_reg != SQ_RUN) || !slot_free;
    assign accept    = in_valid && !in_stall;
    assign nb_addr   = send_position_reg + BUF_AW'(1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            buf_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= buf_mem[mem_ra];
    end

    // ------------------------------------------------------------------
    // Next state and result
    // ------------------------------------------------------------------
    always_comb
    begin
        logic       level;
        logic [7:0] tc;
        logic [7:0] prio_c;
        logic [7:0] chk_fold;
        logic [LEN_W-1:0] len_sat;
        mode_t      m;
        status_t    st;

        level   = (line_now & sample_early) | (line_now & sample_mid) |
                  (sample_early & sample_mid);
        tc      = tick_count_reg;
        prio_c  = (try_prio_reg > backoff_limit_reg) ? backoff_limit_reg : try_prio_reg;
        m       = mode_reg;
        st      = ST_NONE;

        len_sat = packet_length;
        if (packet_length < LEN_MIN)
        begin
            len_sat = LEN_MIN;
        end
        else if (packet_length > LEN_MAX)
        begin
            len_sat = LEN_MAX;
        end

        mode_next          = mode_reg;
        start_seen_next    = start_seen_reg;
        tick_count_next    = tick_count_reg;
        shift_byte_next    = shift_byte_reg;
        send_position_next = send_position_reg;
        send_length_next   = send_length_reg;
        line_pulled_next   = line_pulled_reg;

        seq_next        = seq_reg;
        sweep_idx_next  = sweep_idx_reg;
        land_next       = 1'b0;
        land_first_next = 1'b0;
        chk_next        = chk_reg;
        first_next      = first_reg;
        try_len_next    = try_len_reg;
        try_prio_next   = try_prio_reg;
        try_edge_next   = try_edge_reg;

        mem_we      = 1'b0;
        mem_wa      = buf_index;
        mem_wd      = buf_byte;
        fetch_issue = 1'b0;
        fetch_addr  = nb_addr;

        out_valid_next = out_valid_reg && out_stall;
        drive_low_next = drive_low_reg;
        rx_valid_next  = rx_valid_reg;
        rx_data_next   = rx_data_reg;
        rx_error_next  = rx_error_reg;
        tx_status_next = tx_status_reg;
        coll_end_next  = coll_end_reg;
        bus_state_next = bus_state_reg;

        // sweep data folds into the checksum as it lands
        chk_fold = chk_reg;
        if (land_reg)
        begin
            chk_fold = chk_reg ^ rd_data_reg;
            chk_next = chk_fold;
            if (land_first_reg)
            begin
                first_next = rd_data_reg;
            end
        end

        unique case (seq_reg)
            SQ_RUN:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    rx_valid_next  = 1'b0;
                    rx_data_next   = 8'd0;
                    rx_error_next  = 1'b0;
                    coll_end_next  = 1'b0;
                    unique case (cmd_t'(command))
                        CMD_LOAD:
                        begin
                            mem_we = (LEN_W'(buf_index) < LEN_MAX);
                        end
                        CMD_TRY:
                        begin
                            out_valid_next = 1'b0;
                            try_len_next   = len_sat;
                            try_prio_next  = priority_delay;
                            try_edge_next  = edge_pending;
                            chk_next       = CHECK_SEED;
                            sweep_idx_next = '0;
                            seq_next       = SQ_SWEEP;
                        end
                        CMD_EDGE:
                        begin
                            if (!start_seen_reg &&
                                (mode_reg == MODE_IDLE || mode_reg == MODE_BACKOFF))
                            begin
                                start_seen_next = 1'b1;
                            end
                        end
                        CMD_CHECK:
                        begin
                            if (start_seen_reg && line_now)
                            begin
                                start_seen_next = 1'b0;
                                rx_error_next   = 1'b1;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (start_seen_reg || mode_reg != MODE_IDLE)
                            begin
                                if (tc != TICK_SAT)
                                begin
                                    tc = tc + 8'd1;
                                end
                                if (start_seen_reg)
                                begin
                                    start_seen_next = 1'b0;
                                    m  = MODE_RX;
                                    tc = 8'd0;
                                end
                                else
                                begin
                                    if (m == MODE_RX)
                                    begin
                                        if (tc < STOP_TICK)
                                        begin
                                            shift_byte_next = (shift_byte_reg >> 1) |
                                                              (level ? DATA_MSB : 8'd0);
                                        end
                                        else
                                        begin
                                            if (level)
                                            begin
                                                rx_valid_next = 1'b1;
                                                rx_data_next  = shift_byte_reg;
                                            end
                                            else
                                            begin
                                                rx_error_next = 1'b1;
                                            end
                                            tc = 8'd0;
                                            m  = MODE_BACKOFF;
                                        end
                                    end
                                    if (m == MODE_TX)
                                    begin
                                        if (line_pulled_reg == level)
                                        begin
                                            tc = 8'd0;
                                            m  = MODE_BREAK;
                                            st = ST_COLL;
                                        end
                                        else if (tc < STOP_TICK)
                                        begin
                                            line_pulled_next = !shift_byte_reg[0];
                                            shift_byte_next  = shift_byte_reg >> 1;
                                        end
                                        else if (tc == STOP_TICK)
                                        begin
                                            line_pulled_next = 1'b0;
                                        end
                                        else if ((LEN_W'(send_position_reg) + LEN_W'(1))
                                                 < send_length_reg)
                                        begin
                                            send_position_next = nb_addr;
                                            tc                 = 8'd0;
                                            shift_byte_next    = next_byte_reg;
                                            line_pulled_next   = 1'b1;
                                            fetch_issue        = 1'b1;
                                            fetch_addr         = nb_addr + BUF_AW'(1);
                                        end
                                        else
                                        begin
                                            st = ST_DONE;
                                            tc = 8'd0;
                                            m  = MODE_BACKOFF;
                                        end
                                    end
                                    if (m == MODE_BREAK)
                                    begin
                                        if (tc == 8'd0)
                                        begin
                                            line_pulled_next = 1'b1;
                                        end
                                        else if (tc >= break_ticks_reg)
                                        begin
                                            line_pulled_next = 1'b0;
                                            tc            = 8'd0;
                                            m             = MODE_BACKOFF;
                                            coll_end_next = 1'b1;
                                        end
                                    end
                                    if (m == MODE_BACKOFF && tc != 8'd0 &&
                                        tc >= backoff_limit_reg)
                                    begin
                                        m = MODE_IDLE;
                                    end
                                end
                                mode_next       = m;
                                tick_count_next = tc;
                            end
                        end
                        default: ;
                    endcase
                    tx_status_next = st;
                    drive_low_next = line_pulled_next;
                    bus_state_next = mode_next;
                end
            end
            SQ_SWEEP:
            begin
                land_next       = 1'b1;
                land_first_next = (sweep_idx_reg == '0);
                if (sweep_idx_reg == BUF_AW'(try_len_reg - LEN_MIN))
                begin
                    seq_next = SQ_FOLD;
                end
                else
                begin
                    sweep_idx_next = sweep_idx_reg + BUF_AW'(1);
                end
            end
            SQ_FOLD:
            begin
                seq_next = SQ_FIN;
            end
            SQ_FIN:
            begin
                if (slot_free)
                begin
                    seq_next = SQ_RUN;
                    mem_we   = 1'b1;
                    mem_wa   = BUF_AW'(try_len_reg - LEN_W'(1));
                    mem_wd   = chk_reg;

                    if (!start_seen_reg && m == MODE_BACKOFF && tc >= prio_c)
                    begin
                        m = MODE_IDLE;
                    end
                    if (!start_seen_reg && m == MODE_BACKOFF)
                    begin
                        st = (tc < carrier_ticks_reg) ? ST_CARRIER : ST_PRIO;
                    end
                    else if (start_seen_reg || m != MODE_IDLE || try_edge_reg)
                    begin
                        st = ST_BUSY;
                    end
                    else
                    begin
                        line_pulled_next   = 1'b1;
                        send_length_next   = try_len_reg;
                        send_position_next = '0;
                        shift_byte_next    = first_reg;
                        m                  = MODE_TX;
                        tick_count_next    = 8'd0;
                        st                 = ST_STARTED;
                        fetch_issue        = 1'b1;
                        fetch_addr         = BUF_AW'(1);
                    end
                    mode_next = m;

                    out_valid_next = 1'b1;
                    drive_low_next = line_pulled_next;
                    rx_valid_next  = 1'b0;
                    rx_data_next   = 8'd0;
                    rx_error_next  = 1'b0;
                    tx_status_next = st;
                    coll_end_next  = 1'b0;
                    bus_state_next = m;
                end
            end
            default: ;
        endcase

        mem_ra = (seq_reg == SQ_SWEEP) ? sweep_idx_reg : fetch_addr;

        // prefetch tracking: landing fetch, then same-cycle write forward
        next_byte_next = next_byte_reg;
        if (fetch_land_reg)
        begin
            next_byte_next = fetch_hit_reg ? fetch_wd_reg : rd_data_reg;
        end
        if (mem_we && mem_wa == nb_addr)
        begin
            next_byte_next = mem_wd;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            start_seen_reg    <= 1'b0;
            tick_count_reg    <= 8'd0;
            shift_byte_reg    <= 8'd0;
            send_position_reg <= '0;
            send_length_reg   <= '0;
            line_pulled_reg   <= 1'b0;
            seq_reg           <= SQ_RUN;
            land_reg          <= 1'b0;
            land_first_reg    <= 1'b0;
            fetch_land_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            mode_reg          <= mode_next;
            start_seen_reg    <= start_seen_next;
            tick_count_reg    <= tick_count_next;
            shift_byte_reg    <= shift_byte_next;
            send_position_reg <= send_position_next;
            send_length_reg   <= send_length_next;
            line_pulled_reg   <= line_pulled_next;
            seq_reg           <= seq_next;
            land_reg          <= land_next;
            land_first_reg    <= land_first_next;
            fetch_land_reg    <= fetch_issue;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sweep_idx_reg  <= sweep_idx_next;
        chk_reg        <= chk_next;
        first_reg      <= first_next;
        try_len_reg    <= try_len_next;
        try_prio_reg   <= try_prio_next;
        try_edge_reg   <= try_edge_next;
        next_byte_reg  <= next_byte_next;
        fetch_hit_reg  <= fetch_issue && mem_we && (mem_wa == fetch_addr);
        fetch_wd_reg   <= mem_wd;
        drive_low_reg  <= drive_low_next;
        rx_valid_reg   <= rx_valid_next;
        rx_data_reg    <= rx_data_next;
        rx_error_reg   <= rx_error_next;
        tx_status_reg  <= tx_status_next;
        coll_end_reg   <= coll_end_next;
        bus_state_reg  <= bus_state_next;
    end

    assign out_valid     = out_valid_reg;
    assign drive_low     = drive_low_reg;
    assign rx_valid      = rx_valid_reg;
    assign rx_data       = rx_data_reg;
    assign rx_error      = rx_error_reg;
    assign tx_status     = tx_status_reg;
    assign collision_end = coll_end_reg;
    assign bus_state     = bus_state_reg;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the collision-detect bit UART. A local event model
// predicts one result per accepted request (line drive, received byte, framing
// and noise flags, transmit status, break release, bus mode); results are
// compared in order. Runs directed corner events and a buffer fill, then packet,
// frame and noise traffic under several register settings and handshake idling patterns.
// ============================================================================
module tb_top;

    import cdbu_pkg::*;

    localparam int          STALL_LIMIT   = 3000;  // cycles with no handshake at all
    localparam int          TICK_CAP      = 600;   // requests sent while one packet sequence settles
    localparam int          MAX_PRINTED   = 100;
    localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0] command;
        logic [6:0] buf_index;
        logic [7:0] buf_byte;
        logic [7:0] packet_length;
        logic [7:0] priority_delay;
        logic       edge_pending;
        logic       line_now;
        logic       sample_early;
        logic       sample_mid;
    } request_t;

    typedef struct packed {
        logic       drive_low;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       rx_error;
        status_t    tx_status;
        logic       collision_end;
        mode_t      bus_state;
    } uart_result_t;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] command;
    logic [6:0] buf_index;
    logic [7:0] buf_byte;
    logic [7:0] packet_length;
    logic [7:0] priority_delay;
    logic       edge_pending;
    logic       line_now;
    logic       sample_early;
    logic       sample_mid;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       drive_low;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_error;
    logic [2:0] tx_status;
    logic       collision_end;
    logic [2:0] bus_state;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    collision_detect_bit_uart_top dut (.*);

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    uart_result_t expected_results[$];
    int           mismatch_count;
    int           useful_requests;     // requests that were not simply dropped
    int           traffic_goal;        // useful_requests level that ends a traffic run
    int           sender_idle_pct;
    int           receiver_stall_pct;
    int           quiet_cycles = 0;

    // Event model state, mirrors the block
    logic [7:0] cfg_backoff_limit;
    logic [7:0] cfg_carrier_ticks;
    logic [7:0] cfg_break_ticks;
    mode_t      bus_mode;
    logic       start_flag;
    logic [7:0] bit_ticks;
    logic [7:0] shift_reg;
    logic [6:0] tx_pos;
    logic [7:0] tx_len;
    logic [7:0] tx_check;
    logic       pulling_low;
    logic [7:0] tx_buf [BUF_DEPTH];
    bit         tx_buf_loaded [BUF_DEPTH];

    // ------------------------------------------------------------------------
    // Clock: 12 ns period
    // ------------------------------------------------------------------------
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Event model
    // ------------------------------------------------------------------------
    task automatic reset_model();
        cfg_backoff_limit = 8'd40;
        cfg_carrier_ticks = 8'd20;
        cfg_break_ticks   = 8'd15;
        bus_mode          = MODE_IDLE;
        start_flag        = 1'b0;
        bit_ticks         = '0;
        shift_reg         = '0;
        tx_pos            = '0;
        tx_len            = '0;
        tx_check          = CHECK_SEED;
        pulling_low       = 1'b0;
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            tx_buf[i]        = '0;
            tx_buf_loaded[i] = 1'b0;
        end
    endtask

    function automatic int clip_length(input logic [7:0] raw);
        if (raw < 8'd2)
            return 2;
        if (int'(raw) > BUF_DEPTH)
            return BUF_DEPTH;
        return int'(raw);
    endfunction

    // Transmit try: checksum is folded and stored whatever the outcome
    function automatic status_t start_attempt(input request_t r);
        int         len;
        logic [7:0] prio;
        len      = clip_length(r.packet_length);
        tx_check = CHECK_SEED;
        for (int i = 0; i < len - 1; i++)
            tx_check = tx_check ^ tx_buf[i];
        tx_buf[len-1]        = tx_check;
        tx_buf_loaded[len-1] = 1'b1;

        prio = (r.priority_delay > cfg_backoff_limit) ? cfg_backoff_limit : r.priority_delay;
        if (!start_flag && bus_mode == MODE_BACKOFF && bit_ticks >= prio)
            bus_mode = MODE_IDLE;
        if (!start_flag && bus_mode == MODE_BACKOFF)
            return (bit_ticks < cfg_carrier_ticks) ? ST_CARRIER : ST_PRIO;
        if (start_flag || bus_mode != MODE_IDLE || r.edge_pending)
            return ST_BUSY;

        pulling_low = 1'b1;
        tx_len      = 8'(len);
        tx_pos      = '0;
        shift_reg   = tx_buf[0];
        bus_mode    = MODE_TX;
        bit_ticks   = '0;
        return ST_STARTED;
    endfunction

    function automatic uart_result_t predict_uart_event(input request_t r, output bit ignored);
        uart_result_t res;
        logic         level;
        res               = '0;
        res.tx_status     = ST_NONE;
        ignored           = 1'b0;
        case (r.command)
            CMD_LOAD:
            begin
                tx_buf[r.buf_index]        = r.buf_byte;
                tx_buf_loaded[r.buf_index] = 1'b1;
            end
            CMD_TRY:
                res.tx_status = start_attempt(r);
            CMD_EDGE:
            begin
                if (!start_flag && (bus_mode == MODE_IDLE || bus_mode == MODE_BACKOFF))
                    start_flag = 1'b1;
                else
                    ignored = 1'b1;
            end
            CMD_CHECK:
            begin
                if (!start_flag)
                    ignored = 1'b1;
                else if (r.line_now)
                begin
                    // start bit high at its check: noise, drop the reception
                    start_flag   = 1'b0;
                    res.rx_error = 1'b1;
                end
            end
            CMD_TICK:
            begin
                if (!start_flag && bus_mode == MODE_IDLE)
                    ignored = 1'b1;
                else
                begin
                    level = (r.line_now & r.sample_early) | (r.line_now & r.sample_mid)
                          | (r.sample_early & r.sample_mid);
                    if (bit_ticks != TICK_SAT)
                        bit_ticks = bit_ticks + 8'd1;

                    if (start_flag)
                    begin
                        start_flag = 1'b0;
                        bus_mode   = MODE_RX;
                        bit_ticks  = '0;
                    end
                    else
                    begin
                        if (bus_mode == MODE_RX)
                        begin
                            if (bit_ticks < STOP_TICK)
                                shift_reg = {level, shift_reg[7:1]};
                            else
                            begin
                                if (level)
                                begin
                                    res.rx_valid = 1'b1;
                                    res.rx_data  = shift_reg;
                                end
                                else
                                    res.rx_error = 1'b1;
                                bit_ticks = '0;
                                bus_mode  = MODE_BACKOFF;
                            end
                        end
                        if (bus_mode == MODE_TX)
                        begin
                            if (pulling_low == level)
                            begin
                                bit_ticks     = '0;
                                bus_mode      = MODE_BREAK;
                                res.tx_status = ST_COLL;
                            end
                            else if (bit_ticks < STOP_TICK)
                            begin
                                pulling_low = !shift_reg[0];
                                shift_reg   = shift_reg >> 1;
                            end
                            else if (bit_ticks == STOP_TICK)
                                pulling_low = 1'b0;
                            else if (int'(tx_pos) + 1 < int'(tx_len))
                            begin
                                tx_pos      = tx_pos + 7'd1;
                                bit_ticks   = '0;
                                shift_reg   = tx_buf[tx_pos];
                                pulling_low = 1'b1;
                            end
                            else
                            begin
                                res.tx_status = ST_DONE;
                                bit_ticks     = '0;
                                bus_mode      = MODE_BACKOFF;
                            end
                        end
                        if (bus_mode == MODE_BREAK)
                        begin
                            if (bit_ticks == 8'd0)
                                pulling_low = 1'b1;
                            else if (bit_ticks >= cfg_break_ticks)
                            begin
                                pulling_low       = 1'b0;
                                bit_ticks         = '0;
                                bus_mode          = MODE_BACKOFF;
                                res.collision_end = 1'b1;
                            end
                        end
                        if (bus_mode == MODE_BACKOFF && bit_ticks != 8'd0
                            && bit_ticks >= cfg_backoff_limit)
                            bus_mode = MODE_IDLE;
                    end
                end
            end
            default:
                ignored = 1'b1;
        endcase
        res.drive_low = pulling_low;
        res.bus_state = bus_mode;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request channel driver
    // ------------------------------------------------------------------------
    task automatic send_request(input request_t r);
        uart_result_t want;
        bit           ignored;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        command        <= r.command;
        buf_index      <= r.buf_index;
        buf_byte       <= r.buf_byte;
        packet_length  <= r.packet_length;
        priority_delay <= r.priority_delay;
        edge_pending   <= r.edge_pending;
        line_now       <= r.line_now;
        sample_early   <= r.sample_early;
        sample_mid     <= r.sample_mid;
        do
            @(posedge clk);
        while (in_stall);
        want = predict_uart_event(r, ignored);
        expected_results.push_back(want);
        if (!ignored)
            useful_requests++;
    endtask

    // Drop valid and hold off until every outstanding result is back
    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            CFG_BACKOFF_LIMIT: cfg_backoff_limit = value;
            CFG_CARRIER_TICKS: cfg_carrier_ticks = value;
            CFG_BREAK_TICKS:   cfg_break_ticks   = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_registers(input logic [7:0] backoff, input logic [7:0] carrier,
                                 input logic [7:0] brk);
        wait_results_drained();
        write_register(CFG_BACKOFF_LIMIT, backoff);
        write_register(CFG_CARRIER_TICKS, carrier);
        write_register(CFG_BREAK_TICKS, brk);
    endtask

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------
    function automatic request_t build_request(input logic [2:0] cmd, input int index,
                                               input int data_byte, input int length,
                                               input int prio, input bit edge_bit,
                                               input logic [2:0] lines);
        request_t r;
        r.command        = cmd;
        r.buf_index      = 7'(index);
        r.buf_byte       = 8'(data_byte);
        r.packet_length  = 8'(length);
        r.priority_delay = 8'(prio);
        r.edge_pending   = edge_bit;
        {r.line_now, r.sample_early, r.sample_mid} = lines;
        return r;
    endfunction

    function automatic request_t random_request();
        request_t r;
        r.command        = 3'($urandom_range(7));
        r.buf_index      = 7'($urandom);
        r.buf_byte       = 8'($urandom);
        r.packet_length  = 8'($urandom);
        r.priority_delay = 8'($urandom);
        r.edge_pending   = 1'($urandom);
        r.line_now       = 1'($urandom);
        r.sample_early   = 1'($urandom);
        r.sample_mid     = 1'($urandom);
        return r;
    endfunction

    // Tick with all three samples at one level, sometimes one sample flipped
    function automatic request_t tick_request(input logic level, input int noise_pct);
        request_t r;
        r              = random_request();
        r.command      = CMD_TICK;
        r.line_now     = level;
        r.sample_early = level;
        r.sample_mid   = level;
        if ($urandom_range(99) < noise_pct)
        begin
            case ($urandom_range(2))
                0:       r.line_now     = !level;
                1:       r.sample_early = !level;
                default: r.sample_mid   = !level;
            endcase
        end
        return r;
    endfunction

    // Packet length whose checksum fold only touches loaded buffer entries
    function automatic logic [7:0] pick_length();
        int room;
        int k;
        room = 0;
        while (room < BUF_DEPTH && tx_buf_loaded[room])
            room++;
        room = (room + 1 > BUF_DEPTH) ? BUF_DEPTH : room + 1;
        k = $urandom_range(99);
        if (k < 5)
            return 8'($urandom_range(1));           // saturates up to 2
        if (k < 8 && room == BUF_DEPTH)
            return 8'($urandom_range(255, BUF_DEPTH)); // saturates down
        if (k < 12)
            return 8'($urandom_range(room, 2));
        return 8'($urandom_range((room < 8) ? room : 8, 2));
    endfunction

    // ------------------------------------------------------------------------
    // Traffic sequences
    // ------------------------------------------------------------------------

    // Load a few bytes, try to send, then clock the bus until it settles.
    // Line levels follow our own drive so the packet runs, with rare collisions.
    // Stops early once the traffic run has sent its share.
    task automatic run_packet();
        request_t   r;
        logic [7:0] plen;
        logic       level;
        int         room;
        int         steps;
        int         k;
        plen = pick_length();
        room = clip_length(plen) - 1;
        repeat ($urandom_range(4))
        begin
            r           = random_request();
            r.command   = CMD_LOAD;
            r.buf_index = 7'($urandom_range(room - 1));
            send_request(r);
        end
        r                = random_request();
        r.command        = CMD_TRY;
        r.packet_length  = plen;
        r.priority_delay = $urandom_range(1) ? 8'($urandom_range(8)) : 8'($urandom);
        r.edge_pending   = ($urandom_range(9) == 0);
        send_request(r);

        steps = 0;
        while ((bus_mode != MODE_IDLE || start_flag) && steps < TICK_CAP
               && useful_requests < traffic_goal)
        begin
            k = $urandom_range(99);
            if (k < 3)
            begin
                // stray edge or try while the bus is occupied
                r               = random_request();
                r.command       = $urandom_range(1) ? CMD_EDGE : CMD_TRY;
                r.packet_length = pick_length();
                send_request(r);
            end
            else if (k < 10 && bus_mode == MODE_BACKOFF)
            begin
                // contend for the bus during backoff
                r                = random_request();
                r.command        = CMD_TRY;
                r.packet_length  = pick_length();
                r.priority_delay = 8'($urandom_range(cfg_backoff_limit));
                r.edge_pending   = 1'b0;
                send_request(r);
            end
            else
            begin
                if (bus_mode == MODE_TX)
                    level = ($urandom_range(99) == 0) ? pulling_low : !pulling_low;
                else
                    level = 1'($urandom_range(1));
                send_request(tick_request(level, 15));
            end
            steps++;
        end
    endtask

    // Remote frame: edge, usually a start-bit check, start tick, 8 data bits, stop bit
    task automatic run_frame();
        request_t   r;
        logic [7:0] data;
        int         k;
        data      = 8'($urandom);
        r         = random_request();
        r.command = CMD_EDGE;
        send_request(r);
        k = $urandom_range(99);
        if (k < 92)
        begin
            r          = random_request();
            r.command  = CMD_CHECK;
            r.line_now = (k >= 85);     // high start bit is a noise start
            send_request(r);
        end
        send_request(tick_request(1'b0, 15));
        for (int i = 0; i < 8; i++)
            send_request(tick_request(data[i], 15));
        send_request(tick_request($urandom_range(9) != 0, 15));
    endtask

    task automatic run_noise();
        request_t r;
        repeat ($urandom_range(5, 1))
        begin
            r = random_request();
            if (r.command == CMD_TRY)
                r.packet_length = pick_length();
            send_request(r);
        end
    endtask

    task automatic run_traffic(input int count);
        int k;
        traffic_goal = useful_requests + count;
        while (useful_requests < traffic_goal)
        begin
            k = $urandom_range(99);
            if (k < 45)
                run_packet();
            else if (k < 85)
                run_frame();
            else
                run_noise();
            // now and then let the pipe run dry before continuing
            if ($urandom_range(39) == 0)
                wait_results_drained();
        end
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Short registers so break, backoff and both refusal statuses show up fast
    task automatic test_corner_events();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        set_registers(8'd3, 8'd2, 8'd1);
        send_request(build_request(CMD_UNUSED_LO, 0, 0, 0, 0, 0, 3'b000));
        send_request(build_request(CMD_UNUSED_HI, 127, 255, 255, 255, 1, 3'b111));
        send_request(build_request(CMD_TICK, 0, 0, 0, 0, 0, 3'b000));   // timer stopped
        send_request(build_request(CMD_CHECK, 0, 0, 0, 0, 0, 3'b111));  // no edge seen
        send_request(build_request(CMD_LOAD, 0, 8'h00, 0, 0, 0, 3'b000));
        send_request(build_request(CMD_LOAD, 127, 8'hFF, 0, 0, 0, 3'b000));
        send_request(build_request(CMD_LOAD, 1, 8'h5A, 0, 0, 0, 3'b000));
        // zero length saturates to 2; edge pending keeps a free bus busy
        send_request(build_request(CMD_TRY, 0, 0, 0, 0, 1, 3'b000));
        send_request(build_request(CMD_TRY, 0, 0, 2, 255, 0, 3'b000));
        send_request(build_request(CMD_TICK, 0, 0, 0, 0, 0, 3'b000));   // matches drive
        send_request(build_request(CMD_TICK, 0, 0, 0, 0, 0, 3'b111));   // collision
        send_request(build_request(CMD_TICK, 0, 0, 0, 0, 0, 3'b101));   // break released
        send_request(build_request(CMD_TRY, 0, 0, 2, 255, 0, 3'b000));  // carrier wait
        send_request(build_request(CMD_TICK, 0, 0, 0, 0, 0, 3'b010));
        send_request(build_request(CMD_TICK, 0, 0, 0, 0, 0, 3'b001));
        send_request(build_request(CMD_TRY, 0, 0, 2, 200, 0, 3'b000));  // priority wait
        send_request(build_request(CMD_EDGE, 0, 0, 0, 0, 0, 3'b000));
        send_request(build_request(CMD_TRY, 0, 0, 2, 0, 0, 3'b000));    // start pending
        send_request(build_request(CMD_CHECK, 0, 0, 0, 0, 0, 3'b100));  // noise start
        send_request(build_request(CMD_EDGE, 0, 0, 0, 0, 0, 3'b000));
        // reception begins on a tick without a start-bit check
        send_request(build_request(CMD_TICK, 0, 0, 0, 0, 0, 3'b100));
        send_request(build_request(CMD_EDGE, 0, 0, 0, 0, 0, 3'b000));   // not free: dropped
        send_request(build_request(CMD_TRY, 0, 0, 2, 0, 1, 3'b000));    // receiving: busy
        wait_results_drained();
    endtask

    task automatic test_buffer_fill();
        sender_idle_pct    = 32;
        receiver_stall_pct = 32;
        for (int i = 0; i < BUF_DEPTH; i++)
            send_request(build_request(CMD_LOAD, i, $urandom_range(255), $urandom_range(255),
                                       $urandom_range(255), 1'($urandom), 3'($urandom)));
        wait_results_drained();
    endtask

    task automatic test_default_settings();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        set_registers(8'd40, 8'd20, 8'd15);
        run_traffic(380);
    endtask

    // Bus frees on the first backoff tick and breaks are one tick long
    task automatic test_fast_bus();
        sender_idle_pct    = 69;
        receiver_stall_pct = 0;
        set_registers(8'd0, 8'd0, 8'd1);
        run_traffic(420);
    endtask

    task automatic test_slow_bus();
        sender_idle_pct    = 0;
        receiver_stall_pct = 69;
        set_registers(8'd255, 8'd255, 8'd255);
        run_traffic(450);
    endtask

    task automatic test_random_settings();
        sender_idle_pct    = 32;
        receiver_stall_pct = 32;
        repeat (3)
        begin
            set_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(40, 1)));
            run_traffic(160);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t: %s mismatch: got 0x%02h, want 0x%02h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        uart_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unrequested result (bus_state)", 8'(bus_state), 8'h00);
            else
            begin
                want = expected_results.pop_front();
                if (drive_low !== want.drive_low)
                    report_mismatch("drive_low", 8'(drive_low), 8'(want.drive_low));
                if (rx_valid !== want.rx_valid)
                    report_mismatch("rx_valid", 8'(rx_valid), 8'(want.rx_valid));
                if (rx_data !== want.rx_data)
                    report_mismatch("rx_data", rx_data, want.rx_data);
                if (rx_error !== want.rx_error)
                    report_mismatch("rx_error", 8'(rx_error), 8'(want.rx_error));
                if (tx_status !== want.tx_status)
                    report_mismatch("tx_status", 8'(tx_status), 8'(want.tx_status));
                if (collision_end !== want.collision_end)
                    report_mismatch("collision_end", 8'(collision_end),
                                    8'(want.collision_end));
                if (bus_state !== want.bus_state)
                    report_mismatch("bus_state", 8'(bus_state), 8'(want.bus_state));
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < receiver_stall_pct);

    // Watchdog: too long without any handshake means the block has hung
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        command            = CMD_LOAD;
        buf_index          = '0;
        buf_byte           = '0;
        packet_length      = '0;
        priority_delay     = '0;
        edge_pending       = 1'b0;
        line_now           = 1'b0;
        sample_early       = 1'b0;
        sample_mid         = 1'b0;
        cfg_valid          = 1'b0;
        cfg_index          = CFG_BACKOFF_LIMIT;
        cfg_data           = '0;
        mismatch_count     = 0;
        useful_requests    = 0;
        traffic_goal       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        reset_model();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_events();
        test_buffer_fill();
        test_default_settings();
        test_fast_bus();
        test_slow_bus();
        test_random_settings();

        wait_results_drained();
        repeat (8) @(posedge clk);   // catch any stray result
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
